### rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the calculator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

### rtl/core/psc_pkg.sv
// Package with the types, constants and microprogram addresses of the calculator.
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int KIND_W      = 3;
  localparam int DEPTH_OUT_W = 5;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W + 1);
  localparam int UPC_W       = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_NUM   = 3'd0,
    KIND_ADD   = 3'd1,
    KIND_SUB   = 3'd2,
    KIND_MUL   = 3'd3,
    KIND_DIV   = 3'd4,
    KIND_CLEAR = 3'd5,
    KIND_NOP6  = 3'd6,
    KIND_NOP7  = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_CLEAR,
    ACT_READ,
    ACT_ALU,
    ACT_DIV_START,
    ACT_DIV_LOAD,
    ACT_ZERO,
    ACT_WRITE,
    ACT_EMIT
  } act_e;

  typedef enum logic [3:0] {
    COND_NEXT,
    COND_JUMP,
    COND_DISPATCH,
    COND_FULL,
    COND_UNDER,
    COND_IS_DIV,
    COND_DIV_ZERO,
    COND_WAIT_DIV,
    COND_WAIT_OUT
  } cond_e;

  localparam logic [UPC_W-1:0] UPC_IDLE     = 4'd0;
  localparam logic [UPC_W-1:0] UPC_NUM      = 4'd1;
  localparam logic [UPC_W-1:0] UPC_PUSH     = 4'd2;
  localparam logic [UPC_W-1:0] UPC_OP       = 4'd3;
  localparam logic [UPC_W-1:0] UPC_OP_SEL   = 4'd4;
  localparam logic [UPC_W-1:0] UPC_ALU      = 4'd5;
  localparam logic [UPC_W-1:0] UPC_DIV_CHK  = 4'd6;
  localparam logic [UPC_W-1:0] UPC_DIV_WAIT = 4'd7;
  localparam logic [UPC_W-1:0] UPC_DIV_ZERO = 4'd8;
  localparam logic [UPC_W-1:0] UPC_WRITE    = 4'd9;
  localparam logic [UPC_W-1:0] UPC_CLEAR    = 4'd10;
  localparam logic [UPC_W-1:0] UPC_EMIT     = 4'd11;
  localparam logic [UPC_W-1:0] UPC_OVER     = 4'd12;
  localparam logic [UPC_W-1:0] UPC_UNDER    = 4'd13;

  typedef struct packed {
    act_e             act;
    cond_e            cond;
    logic [UPC_W-1:0] target;
    logic             set_status;
    status_e          status;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic under;
    logic div_zero;
    logic is_div;
    logic div_busy;
    logic out_free;
  } flags_t;

  function automatic logic [UPC_W-1:0] dispatch(input logic [KIND_W-1:0] kind);
    logic [UPC_W-1:0] upc;
    unique case (kind_e'(kind))
      KIND_NUM:                             upc = UPC_NUM;
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: upc = UPC_OP;
      KIND_CLEAR:                           upc = UPC_CLEAR;
      default:                              upc = UPC_EMIT;
    endcase
    return upc;
  endfunction

endpackage

`default_nettype wire

### rtl/core/psc_ucode_rom.sv
// Microcode ROM that holds one control word for each step of the program.
`timescale 1ns / 1ps
`default_nettype none

module psc_ucode_rom (
  input  logic [psc_pkg::UPC_W-1:0] upc_i,
  output psc_pkg::ctrl_t            ctrl_o
);
  import psc_pkg::*;

  always_comb begin
    unique case (upc_i)
      UPC_IDLE:     ctrl_o = '{ACT_NONE,      COND_DISPATCH, UPC_IDLE,     1'b0, ST_OK};
      UPC_NUM:      ctrl_o = '{ACT_NONE,      COND_FULL,     UPC_OVER,     1'b0, ST_OK};
      UPC_PUSH:     ctrl_o = '{ACT_PUSH,      COND_JUMP,     UPC_EMIT,     1'b0, ST_OK};
      UPC_OP:       ctrl_o = '{ACT_READ,      COND_UNDER,    UPC_UNDER,    1'b0, ST_OK};
      UPC_OP_SEL:   ctrl_o = '{ACT_NONE,      COND_IS_DIV,   UPC_DIV_CHK,  1'b0, ST_OK};
      UPC_ALU:      ctrl_o = '{ACT_ALU,       COND_JUMP,     UPC_WRITE,    1'b0, ST_OK};
      UPC_DIV_CHK:  ctrl_o = '{ACT_DIV_START, COND_DIV_ZERO, UPC_DIV_ZERO, 1'b0, ST_OK};
      UPC_DIV_WAIT: ctrl_o = '{ACT_DIV_LOAD,  COND_WAIT_DIV, UPC_WRITE,    1'b0, ST_OK};
      UPC_DIV_ZERO: ctrl_o = '{ACT_ZERO,      COND_NEXT,     UPC_WRITE,    1'b1, ST_DIV0};
      UPC_WRITE:    ctrl_o = '{ACT_WRITE,     COND_JUMP,     UPC_EMIT,     1'b0, ST_OK};
      UPC_CLEAR:    ctrl_o = '{ACT_CLEAR,     COND_JUMP,     UPC_EMIT,     1'b0, ST_OK};
      UPC_EMIT:     ctrl_o = '{ACT_EMIT,      COND_WAIT_OUT, UPC_IDLE,     1'b0, ST_OK};
      UPC_OVER:     ctrl_o = '{ACT_NONE,      COND_JUMP,     UPC_EMIT,     1'b1, ST_OVER};
      UPC_UNDER:    ctrl_o = '{ACT_NONE,      COND_JUMP,     UPC_EMIT,     1'b1, ST_UNDER};
      default:      ctrl_o = '{ACT_NONE,      COND_JUMP,     UPC_IDLE,     1'b0, ST_OK};
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/psc_sequencer.sv
// Step counter of the microprogram with its dispatch and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module psc_sequencer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_accept_i,
  input  logic [psc_pkg::KIND_W-1:0] kind_i,
  input  psc_pkg::ctrl_t             ctrl_i,
  input  psc_pkg::flags_t            flags_i,
  output logic [psc_pkg::UPC_W-1:0]  upc_o,
  output logic                       idle_o
);
  import psc_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d, upc_inc;

  assign upc_inc = upc_q + UPC_W'(1);

  always_comb begin
    upc_d = upc_q;
    unique case (ctrl_i.cond)
      COND_NEXT:     upc_d = upc_inc;
      COND_JUMP:     upc_d = ctrl_i.target;
      COND_DISPATCH: upc_d = in_accept_i ? dispatch(kind_i) : upc_q;
      COND_FULL:     upc_d = flags_i.full ? ctrl_i.target : upc_inc;
      COND_UNDER:    upc_d = flags_i.under ? ctrl_i.target : upc_inc;
      COND_IS_DIV:   upc_d = flags_i.is_div ? ctrl_i.target : upc_inc;
      COND_DIV_ZERO: upc_d = flags_i.div_zero ? ctrl_i.target : upc_inc;
      COND_WAIT_DIV: upc_d = flags_i.div_busy ? upc_q : ctrl_i.target;
      COND_WAIT_OUT: upc_d = flags_i.out_free ? ctrl_i.target : upc_q;
      default:       upc_d = UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign upc_o  = upc_q;
  assign idle_o = (upc_q == UPC_IDLE);

endmodule

`default_nettype wire

### rtl/core/psc_divider.sv
// Iterative signed divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module psc_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [psc_pkg::DATA_W-1:0] dividend_i,
  input  logic [psc_pkg::DATA_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic [psc_pkg::DATA_W-1:0] quotient_o
);
  import psc_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 neg_q;
  logic [DATA_W-1:0]    rem_q, quot_q, dvsr_q;
  logic [DATA_W-1:0]    rem_sh;
  logic [DATA_W:0]      diff;

  assign rem_sh = {rem_q[DATA_W-2:0], quot_q[DATA_W-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, dvsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_W'(DATA_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i[DATA_W-1] ? (DATA_W'(0) - dividend_i) : dividend_i;
      dvsr_q <= divisor_i[DATA_W-1] ? (DATA_W'(0) - divisor_i) : divisor_i;
      neg_q  <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_q  <= diff[DATA_W-1:0];
        quot_q <= {quot_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        quot_q <= {quot_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = neg_q ? (DATA_W'(0) - quot_q) : quot_q;

endmodule

`default_nettype wire

### rtl/core/psc_datapath.sv
// Datapath with the operand stack memory, cached top, arithmetic and output register.
`timescale 1ns / 1ps
`default_nettype none

module psc_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_accept_i,
  input  logic [psc_pkg::KIND_W-1:0]      kind_i,
  input  logic [psc_pkg::DATA_W-1:0]      value_i,
  input  psc_pkg::ctrl_t                  ctrl_i,
  output psc_pkg::flags_t                 flags_o,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [psc_pkg::DATA_W-1:0]      top_value_o,
  output logic [psc_pkg::DEPTH_OUT_W-1:0] stack_depth_o,
  output logic [1:0]                      status_o
);
  import psc_pkg::*;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

  logic [KIND_W-1:0]      kind_q;
  logic [DATA_W-1:0]      value_q, top_q, rd_q, res_q;
  logic [CNT_W-1:0]       count_q, count_m2;
  status_e                status_q;
  logic                   out_valid_q;
  logic [DATA_W-1:0]      out_top_q;
  logic [DEPTH_OUT_W-1:0] out_depth_q;
  status_e                out_status_q;

  logic                   out_free, emit;
  logic                   mem_we;
  logic [PTR_W-1:0]       mem_waddr;
  logic [DATA_W-1:0]      mem_wdata;
  logic [DATA_W-1:0]      mul_lo;
  logic [DATA_W-1:0]      alu_res;
  logic                   div_busy;
  logic [DATA_W-1:0]      div_quot;

  assign count_m2 = count_q - CNT_W'(2);
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (ctrl_i.act == ACT_EMIT) && out_free;

  assign mem_we    = (ctrl_i.act == ACT_PUSH) || (ctrl_i.act == ACT_WRITE);
  assign mem_waddr = (ctrl_i.act == ACT_PUSH) ? count_q[PTR_W-1:0] : count_m2[PTR_W-1:0];
  assign mem_wdata = (ctrl_i.act == ACT_PUSH) ? value_q : res_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (ctrl_i.act == ACT_READ) begin
      rd_q <= stack_mem[count_m2[PTR_W-1:0]];
    end
  end

  assign mul_lo = rd_q * top_q;

  always_comb begin
    unique case (kind_e'(kind_q))
      KIND_ADD: alu_res = rd_q + top_q;
      KIND_SUB: alu_res = rd_q - top_q;
      KIND_MUL: alu_res = mul_lo;
      default:  alu_res = '0;
    endcase
  end

  psc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.act == ACT_DIV_START),
    .dividend_i (rd_q),
    .divisor_i  (top_q),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (ctrl_i.act)
        ACT_PUSH:  count_q <= count_q + CNT_W'(1);
        ACT_WRITE: count_q <= count_q - CNT_W'(1);
        ACT_CLEAR: count_q <= '0;
        default:   count_q <= count_q;
      endcase
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      kind_q   <= kind_i;
      value_q  <= value_i;
      status_q <= ST_OK;
    end else if (ctrl_i.set_status) begin
      status_q <= ctrl_i.status;
    end
    unique case (ctrl_i.act)
      ACT_PUSH:     top_q <= value_q;
      ACT_WRITE:    top_q <= res_q;
      ACT_ALU:      res_q <= alu_res;
      ACT_ZERO:     res_q <= '0;
      ACT_DIV_LOAD: res_q <= div_busy ? res_q : div_quot;
      default:      res_q <= res_q;
    endcase
    if (emit) begin
      out_top_q    <= (count_q == '0) ? '0 : top_q;
      out_depth_q  <= DEPTH_OUT_W'(count_q);
      out_status_q <= status_q;
    end
  end

  assign flags_o.full     = (count_q == CNT_W'(STACK_DEPTH));
  assign flags_o.under    = (count_q < CNT_W'(2));
  assign flags_o.div_zero = (top_q == '0);
  assign flags_o.is_div   = (kind_e'(kind_q) == KIND_DIV);
  assign flags_o.div_busy = div_busy;
  assign flags_o.out_free = out_free;

  assign out_valid_o   = out_valid_q;
  assign top_value_o   = out_top_q;
  assign stack_depth_o = out_depth_q;
  assign status_o      = out_status_q;

endmodule

`default_nettype wire

### rtl/core/postfix_stack_calculator.sv
// Top level of the microcoded postfix calculator.
// A word is taken only while the sequencer rests at its idle step; it then runs one microprogram.
// Arithmetic words read the operand below the top, then run the ALU or the divider before the write-back.
// A divide waits in its wait step while the divider is busy; a divide by zero writes zero instead.
// The next word is taken only after the emit step, which also waits while the sink stalls the output.
// Reset empties the stack at once; stack entries are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none

module postfix_stack_calculator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [psc_pkg::KIND_W-1:0]      kind_i,
  input  logic signed [psc_pkg::DATA_W-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [psc_pkg::DATA_W-1:0] top_value_o,
  output logic [psc_pkg::DEPTH_OUT_W-1:0] stack_depth_o,
  output logic [1:0]                      status_o
);
  import psc_pkg::*;

  logic             idle, in_accept;
  logic [UPC_W-1:0] upc;
  ctrl_t            ctrl;
  flags_t           flags;
  logic [DATA_W-1:0] top_raw;

  assign in_stall_o = !idle;
  assign in_accept  = in_valid_i && idle;

  psc_ucode_rom u_rom (
    .upc_i  (upc),
    .ctrl_o (ctrl)
  );

  psc_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .kind_i      (kind_i),
    .ctrl_i      (ctrl),
    .flags_i     (flags),
    .upc_o       (upc),
    .idle_o      (idle)
  );

  psc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_accept_i   (in_accept),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .ctrl_i        (ctrl),
    .flags_o       (flags),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .top_value_o   (top_raw),
    .stack_depth_o (stack_depth_o),
    .status_o      (status_o)
  );

  assign top_value_o = top_raw;

endmodule

`default_nettype wire

### rtl/core/psc_checker.sv
// Port-level checker for the calculator and the bind that attaches it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module psc_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_o,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic [psc_pkg::DATA_W-1:0]      top_value_o,
  input  logic [psc_pkg::DEPTH_OUT_W-1:0] stack_depth_o,
  input  logic [1:0]                      status_o
);
  import psc_pkg::*;

  `ASSERT_NXT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_IMP(a_empty_top_zero, clk_i, rst_ni, out_valid_o && (stack_depth_o == '0), top_value_o == '0)
  `ASSERT_IMP(a_under_shallow, clk_i, rst_ni, out_valid_o && (status_o == ST_UNDER), stack_depth_o < 5'd2)
  `ASSERT_IMP(a_over_full, clk_i, rst_ni, out_valid_o && (status_o == ST_OVER), stack_depth_o == DEPTH_OUT_W'(STACK_DEPTH))

endmodule

bind postfix_stack_calculator psc_checker u_psc_checker (.*);

`default_nettype wire
